/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int IN_VALUE_W  = 32;
    localparam int IN_PRIO_W   = 8;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_PRIO_W  = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 4;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CMP,
        S_PUSH_LAST,
        S_POP_HEAD,
        S_POP_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0]     count;
        t_status                status;
        logic [OUT_PRIO_W-1:0]  prio;
        logic [OUT_VALUE_W-1:0] value;
    } t_result;

endpackage

/* rtl/spq_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 40,
    parameter int ADDR_W = 3
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: walks the entry store one slot per cycle with a single
// priority comparator, shifting entries to open or close a gap.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int DEPTH       = 8,
    parameter int VALUE_WIDTH = 32,
    parameter int PRIO_WIDTH  = 8,
    parameter int ADDR_W      = 3,
    parameter int CNT_W       = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  spq_pkg::t_op                       i_op,
    input  logic [spq_pkg::IN_VALUE_W-1:0]     i_value,
    input  logic [spq_pkg::IN_PRIO_W-1:0]      i_prio,
    input  logic                               i_out_free,
    output logic                               o_done,
    output spq_pkg::t_result                   o_res,
    output logic                               o_mem_we,
    output logic [ADDR_W-1:0]                  o_mem_waddr,
    output logic [PRIO_WIDTH+VALUE_WIDTH-1:0]  o_mem_wdata,
    output logic [ADDR_W-1:0]                  o_mem_raddr,
    input  logic [PRIO_WIDTH+VALUE_WIDTH-1:0]  i_mem_rdata
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

    spq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [PRIO_WIDTH-1:0]  r_pri, n_pri;
    logic [spq_pkg::OUT_VALUE_W-1:0] r_res_value, n_res_value;
    logic [spq_pkg::OUT_PRIO_W-1:0]  r_res_prio, n_res_prio;
    spq_pkg::t_status       r_status, n_status;

    // fit input and output fields to the storage widths
    logic [VALUE_WIDTH+spq_pkg::IN_VALUE_W-1:0]  w_in_val_ext;
    logic [PRIO_WIDTH+spq_pkg::IN_PRIO_W-1:0]    w_in_pri_ext;
    logic [VALUE_WIDTH+spq_pkg::OUT_VALUE_W-1:0] w_rd_val_ext;
    logic [PRIO_WIDTH+spq_pkg::OUT_PRIO_W-1:0]   w_rd_pri_ext;
    logic [CNT_W+spq_pkg::COUNT_W-1:0]           w_count_ext;
    logic [VALUE_WIDTH-1:0] w_in_val;
    logic [PRIO_WIDTH-1:0]  w_in_pri;
    logic [VALUE_WIDTH-1:0] w_rd_val;
    logic [PRIO_WIDTH-1:0]  w_rd_pri;
    logic                   w_rd_lower;
    logic                   w_accept;
    logic [CNT_W-1:0]       w_idx_dn2;
    logic [CNT_W-1:0]       w_idx_up2;
    logic [CNT_W-1:0]       w_last_slot;

    assign w_in_val_ext = {{VALUE_WIDTH{1'b0}}, i_value};
    assign w_in_pri_ext = {{PRIO_WIDTH{1'b0}}, i_prio};
    assign w_in_val     = w_in_val_ext[VALUE_WIDTH-1:0];
    assign w_in_pri     = w_in_pri_ext[PRIO_WIDTH-1:0];
    assign w_rd_val     = i_mem_rdata[VALUE_WIDTH-1:0];
    assign w_rd_pri     = i_mem_rdata[PRIO_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];
    assign w_rd_val_ext = {{spq_pkg::OUT_VALUE_W{1'b0}}, w_rd_val};
    assign w_rd_pri_ext = {{spq_pkg::OUT_PRIO_W{1'b0}}, w_rd_pri};
    assign w_count_ext  = {{spq_pkg::COUNT_W{1'b0}}, r_count};

    // the one comparator: does the stored entry yield to the new one
    assign w_rd_lower  = (w_rd_pri < r_pri);
    assign w_accept    = i_valid && (r_state == spq_pkg::S_IDLE);
    assign w_idx_dn2   = r_idx - TWO;
    assign w_idx_up2   = r_idx + TWO;
    assign w_last_slot = r_count - ONE;

    assign o_ready = (r_state == spq_pkg::S_IDLE);
    assign o_done  = (r_state == spq_pkg::S_DONE);
    assign o_res   = '{count:  w_count_ext[spq_pkg::COUNT_W-1:0],
                       status: r_status,
                       prio:   r_res_prio,
                       value:  r_res_value};

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_val       = r_val;
        n_pri       = r_pri;
        n_res_value = r_res_value;
        n_res_prio  = r_res_prio;
        n_status    = r_status;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_val       = w_in_val;
                    n_pri       = w_in_pri;
                    n_res_value = '0;
                    n_res_prio  = '0;
                    n_status    = spq_pkg::ST_OK;
                    if (i_op == spq_pkg::OP_PUSH) begin
                        if (r_count == FULL) begin
                            n_status = spq_pkg::ST_OVERFLOW;
                            n_state  = spq_pkg::S_DONE;
                        end else if (r_count == '0) begin
                            n_count = ONE;
                            n_state = spq_pkg::S_DONE;
                        end else begin
                            n_idx   = r_count;
                            n_state = spq_pkg::S_PUSH_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = spq_pkg::ST_EMPTY;
                            n_state  = spq_pkg::S_DONE;
                        end else begin
                            n_state = spq_pkg::S_POP_HEAD;
                        end
                    end
                end
            end
            spq_pkg::S_PUSH_CMP: begin
                if (w_rd_lower) begin
                    n_idx = r_idx - ONE;
                    if (r_idx == ONE) begin
                        n_state = spq_pkg::S_PUSH_LAST;
                    end
                end else begin
                    n_count = r_count + ONE;
                    n_state = spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_PUSH_LAST: begin
                n_count = r_count + ONE;
                n_state = spq_pkg::S_DONE;
            end
            spq_pkg::S_POP_HEAD: begin
                n_res_value = w_rd_val_ext[spq_pkg::OUT_VALUE_W-1:0];
                n_res_prio  = w_rd_pri_ext[spq_pkg::OUT_PRIO_W-1:0];
                n_idx       = '0;
                if (r_count == ONE) begin
                    n_count = '0;
                    n_state = spq_pkg::S_DONE;
                end else begin
                    n_state = spq_pkg::S_POP_SHIFT;
                end
            end
            spq_pkg::S_POP_SHIFT: begin
                if (w_idx_up2 == r_count) begin
                    n_count = w_last_slot;
                    n_state = spq_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + ONE;
                end
            end
            spq_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = spq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    // store port control
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[ADDR_W-1:0];
        o_mem_wdata = {r_pri, r_val};
        o_mem_raddr = '0;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_accept && (i_op == spq_pkg::OP_PUSH)) begin
                    if (r_count == '0) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = '0;
                        o_mem_wdata = {w_in_pri, w_in_val};
                    end else begin
                        o_mem_raddr = w_last_slot[ADDR_W-1:0];
                    end
                end
            end
            spq_pkg::S_PUSH_CMP: begin
                o_mem_we = 1'b1;
                if (w_rd_lower) begin
                    // move the entry down one slot, fetch the next one up
                    o_mem_wdata = i_mem_rdata;
                    o_mem_raddr = w_idx_dn2[ADDR_W-1:0];
                end
            end
            spq_pkg::S_PUSH_LAST: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
            end
            spq_pkg::S_POP_HEAD: begin
                o_mem_raddr = ONE[ADDR_W-1:0];
            end
            spq_pkg::S_POP_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                o_mem_raddr = w_idx_up2[ADDR_W-1:0];
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_val       <= n_val;
        r_pri       <= n_pri;
        r_res_value <= n_res_value;
        r_res_prio  <= n_res_prio;
        r_status    <= n_status;
    end

endmodule

/* rtl/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue, sorted by descending priority, FIFO among equals.
// ----------------------------------------------------------------------------
// Entries sit in a small store in descending priority order; a push walks
// from the tail toward the head, one slot per cycle through a single
// priority comparator, moving each lower-priority entry down until its slot
// is found, and a pop reads the head and moves the rest up one slot per
// cycle. The input is ready only between requests; a finished result waits
// in the output register while the next request is taken.
module sorted_priority_queue #(
    parameter int DEPTH       = 8,
    parameter int VALUE_WIDTH = 32,
    parameter int PRIO_WIDTH  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // item_value[31:0], item_priority[39:32]
    input  logic        i_s_tuser,   // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // out_value[31:0], out_priority[39:32],
                                     // status[41:40], count[45:42], zero
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ENT_W  = PRIO_WIDTH + VALUE_WIDTH;

    logic                   w_out_free;
    logic                   w_done;
    spq_pkg::t_result       w_res;
    logic                   w_mem_we;
    logic [ADDR_W-1:0]      w_mem_waddr;
    logic [ENT_W-1:0]       w_mem_wdata;
    logic [ADDR_W-1:0]      w_mem_raddr;
    logic [ENT_W-1:0]       w_mem_rdata;
    logic                   r_m_valid;
    spq_pkg::t_result       r_m_res;

    assign w_out_free = !r_m_valid || i_m_tready;

    spq_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .PRIO_WIDTH  (PRIO_WIDTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (spq_pkg::t_op'(i_s_tuser)),
        .i_value     (i_s_tdata[31:0]),
        .i_prio      (i_s_tdata[39:32]),
        .i_out_free  (w_out_free),
        .o_done      (w_done),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    spq_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (ENT_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // output register: load when the sequencer finishes and the slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_out_free) begin
            r_m_res <= w_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_m_res.count, r_m_res.status,
                         r_m_res.prio, r_m_res.value};

endmodule

/* tb/sorted_priority_queue_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// The testbench drives push and pop requests into the sorted priority queue
// while both stream sides stall at random. A scoreboard keeps its own sorted
// copy of the queue, predicts the status, count and removed entry for every
// accepted request, and checks each returned result in order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;

    localparam int DEPTH        = 8;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_ITEMS  = 200;
    localparam int STALL_LIMIT  = 2000;

    class pq_scoreboard;
        logic [spq_pkg::IN_VALUE_W-1:0] held_values[DEPTH];
        logic [spq_pkg::IN_PRIO_W-1:0]  held_prios[DEPTH];
        int unsigned                    held_count;
        spq_pkg::t_result               pending_outcomes[$];
        int                             errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        // Apply one accepted request to the local queue copy and log its outcome.
        function void note_request(spq_pkg::t_op op,
                                   logic [spq_pkg::IN_VALUE_W-1:0] value,
                                   logic [spq_pkg::IN_PRIO_W-1:0] prio);
            spq_pkg::t_result outcome;
            int unsigned      slot;
            outcome        = '0;
            outcome.status = spq_pkg::ST_OK;
            if (op == spq_pkg::OP_PUSH) begin
                if (held_count >= DEPTH) begin
                    outcome.status = spq_pkg::ST_OVERFLOW;
                end else begin
                    slot = held_count;
                    for (int i = 0; i < held_count; i++) begin
                        if (held_prios[i] < prio) begin
                            slot = i;
                            break;
                        end
                    end
                    for (int i = held_count; i > slot; i--) begin
                        held_values[i] = held_values[i-1];
                        held_prios[i]  = held_prios[i-1];
                    end
                    held_values[slot] = value;
                    held_prios[slot]  = prio;
                    held_count++;
                end
            end else begin
                if (held_count == 0) begin
                    outcome.status = spq_pkg::ST_EMPTY;
                end else begin
                    outcome.value = held_values[0];
                    outcome.prio  = held_prios[0];
                    for (int i = 0; i + 1 < held_count; i++) begin
                        held_values[i] = held_values[i+1];
                        held_prios[i]  = held_prios[i+1];
                    end
                    held_count--;
                end
            end
            outcome.count = held_count[spq_pkg::COUNT_W-1:0];
            pending_outcomes.push_back(outcome);
        endfunction

        function void check_result(logic [47:0] tdata);
            spq_pkg::t_result want;
            spq_pkg::t_result got;
            if (pending_outcomes.size() == 0) begin
                $error("result with no request outstanding: tdata %h", tdata);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            got  = spq_pkg::t_result'(tdata[45:0]);
            if (got.value !== want.value) begin
                $error("out_value: expected %h, actual %h", want.value, got.value);
                errors++;
            end
            if (got.prio !== want.prio) begin
                $error("out_priority: expected %0d, actual %0d", want.prio, got.prio);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                errors++;
            end
            if (tdata[47:46] !== 2'b00) begin
                $error("padding: expected 0, actual %b", tdata[47:46]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;    // item_value[31:0], item_priority[39:32]
    logic        i_s_tuser;    // op
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;    // out_value[31:0], out_priority[39:32],
                               // status[41:40], count[45:42], zero

    pq_scoreboard sb;
    bit           quiet;
    int           sink_hold;
    int           stall_cycles;

    sorted_priority_queue #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (spq_pkg::IN_VALUE_W),
        .PRIO_WIDTH  (spq_pkg::IN_PRIO_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Result side: ready with random stall bursts, none in the quiet tail.
    always @(negedge i_clk) begin
        if (sink_hold > 0 && !quiet) begin
            sink_hold  <= sink_hold - 1;
            i_m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            sink_hold  <= $urandom_range(0, 9);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Check results before logging requests taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata);
            if (i_s_tvalid && o_s_tready)
                sb.note_request(spq_pkg::t_op'(i_s_tuser), i_s_tdata[31:0],
                                i_s_tdata[39:32]);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_request(spq_pkg::t_op op,
                                logic [spq_pkg::IN_VALUE_W-1:0] value,
                                logic [spq_pkg::IN_PRIO_W-1:0] prio);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {prio, value};
        forever begin
            @(posedge i_clk);
            if (o_s_tready)
                break;
        end
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random(int push_pct);
        spq_pkg::t_op                   op;
        logic [spq_pkg::IN_VALUE_W-1:0] value;
        logic [spq_pkg::IN_PRIO_W-1:0]  prio;
        op = ($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
        case ($urandom_range(0, 15))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom;
        endcase
        // Narrow priority ranges force ties, so first-in first-out order is hit.
        case ($urandom_range(0, 3))
            0:       prio = 8'($urandom_range(0, 3));
            1:       prio = 8'($urandom_range(0, 255));
            2:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: prio = 8'($urandom_range(8'h7E, 8'h81));
        endcase
        send_request(op, value, prio);
    endtask

    initial begin
        int push_pct;
        sb           = new();
        quiet        = 1'b0;
        sink_hold    = 0;
        stall_cycles = 0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = spq_pkg::OP_PUSH;
        i_m_tready   = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, zero entry, fill with ties, overflow, full drain.
        send_request(spq_pkg::OP_POP,  32'h0000_0000, 8'h00);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0000, 8'h00);
        send_request(spq_pkg::OP_POP,  32'h1234_5678, 8'h12);
        send_request(spq_pkg::OP_PUSH, 32'hFFFF_FFFF, 8'hFF);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0001, 8'h00);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0002, 8'h80);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0003, 8'h80);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0004, 8'hFF);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0005, 8'h80);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0006, 8'h00);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0007, 8'h01);
        send_request(spq_pkg::OP_PUSH, 32'hAAAA_5555, 8'h55);
        send_request(spq_pkg::OP_PUSH, 32'h0000_0000, 8'hFF);
        repeat (8)
            send_request(spq_pkg::OP_POP, 32'hFFFF_FFFF, 8'hFF);
        send_request(spq_pkg::OP_POP, 32'h0000_0000, 8'h00);
        hold_off(1);
        drain_results();

        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Shift the push mix so the queue swings between empty and full.
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if (n % 250 == 125) begin
                hold_off(1);
                drain_results();
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold_off($urandom_range(1, 10));
            end
            send_random(push_pct);
        end
        hold_off(1);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
